// File: design/fepp_pkg.sv
// Shared types and constants for the flash erase/program planner.
`default_nettype none

package fepp_pkg;

   // Default geometry; the top level hands these down as parameters.
   localparam int unsigned WORD_BITS_DEF    = 32;
   localparam int unsigned SECTOR_BYTES_DEF = 4096;
   localparam int unsigned PAGE_BYTES_DEF   = 256;
   localparam int unsigned QUEUE_DEPTH_DEF  = 4;

   // Fixed field widths of the streams.
   localparam int unsigned FIELD_BITS = 32;
   localparam int unsigned ADDR_BITS  = 32;

   // Most commands one input transfer can cause before the done marker is held over.
   localparam int unsigned MAX_RESULTS = 10;

   typedef enum logic [1:0] {
      KIND_ERASE   = 2'd0,
      KIND_PROGRAM = 2'd1,
      KIND_DONE    = 2'd2
   } cmd_kind_type;

   // Fixed part of one sector record passed from front to back.
   typedef struct packed {
      logic                 first;        // first word of a region
      logic                 decide;       // sector closed by this word
      logic                 last;         // region ends with this word
      logic                 erase;        // sector needs an erase
      logic [ADDR_BITS-1:0] sector_start; // byte address of the sector
   } sector_rec_type;

   localparam int unsigned REC_BITS = $bits(sector_rec_type);

endpackage

`default_nettype wire

// File: design/fepp_front.sv
// Front end: accepts word pairs, gathers per-sector flags and issues sector records.
`default_nettype none

module fepp_front
   import fepp_pkg::*;
#(
   parameter int unsigned WORD_BITS    = WORD_BITS_DEF,
   parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
   parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF,
   localparam int unsigned PAGES       = SECTOR_BYTES / PAGE_BYTES,
   localparam int unsigned PIDX_W      = (PAGES > 1) ? $clog2(PAGES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [ADDR_BITS-1:0]  csr_wr_data,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [FIELD_BITS-1:0] old_word,
   input  logic [FIELD_BITS-1:0] new_word,
   input  logic                  end_of_region,
   output logic                  rec_push,
   input  logic                  rec_full,
   output sector_rec_type        rec,
   output logic [PAGES-1:0]      rec_pages,
   output logic [PIDX_W-1:0]     rec_last_page
);

   localparam int unsigned WORD_BYTES = WORD_BITS / 8;
   localparam int unsigned WPS        = SECTOR_BYTES / WORD_BYTES;
   localparam int unsigned WIS_W      = $clog2(WPS);
   localparam int unsigned WPP_SHIFT  = $clog2(PAGE_BYTES / WORD_BYTES);
   localparam int unsigned USED_BITS  = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
   localparam logic [FIELD_BITS-1:0] USED_MASK =
      FIELD_BITS'((64'd1 << USED_BITS) - 64'd1);
   localparam logic BLANK_OK = (WORD_BITS <= FIELD_BITS);

   logic [ADDR_BITS-1:0]  base_ff, base_in;
   logic [WIS_W-1:0]      wis_ff, wis_in;
   logic [ADDR_BITS-1:0]  region_off_ff, region_off_in;
   logic [ADDR_BITS-1:0]  sector_off_ff, sector_off_in;
   logic                  needs_ff, needs_in;
   logic [PAGES-1:0]      diff_ff, diff_in;
   logic [PAGES-1:0]      nb_ff, nb_in;
   logic                  after_end_ff, after_end_in;

   logic [FIELD_BITS-1:0] o_w, n_w;
   logic                  cur_erase, cur_diff, cur_not_blank;
   logic [PIDX_W-1:0]     page_idx;
   logic                  last_word, decide, accept;
   logic                  needs_next;
   logic [PAGES-1:0]      diff_next, nb_next;
   logic [ADDR_BITS-1:0]  next_off;

   assign in_ready = !rec_full;
   assign accept   = in_valid && in_ready;

   assign o_w           = old_word & USED_MASK;
   assign n_w           = new_word & USED_MASK;
   assign cur_erase     = |(n_w & ~o_w);
   assign cur_diff      = (o_w != n_w);
   assign cur_not_blank = !(BLANK_OK && (n_w == USED_MASK));

   assign page_idx   = PIDX_W'(wis_ff >> WPP_SHIFT);
   assign last_word  = (wis_ff == WIS_W'(WPS - 1));
   assign decide     = end_of_region || last_word;
   assign needs_next = needs_ff || cur_erase;
   assign diff_next  = diff_ff | (PAGES'(cur_diff) << page_idx);
   assign nb_next    = nb_ff | (PAGES'(cur_not_blank) << page_idx);
   assign next_off   = region_off_ff + ADDR_BITS'(WORD_BYTES);

   // Record for the back end; pages past the last one are never looked at.
   assign rec_push          = accept && (decide || after_end_ff);
   assign rec.first         = after_end_ff;
   assign rec.decide        = decide;
   assign rec.last          = end_of_region;
   assign rec.erase         = needs_next;
   assign rec.sector_start  = base_ff + sector_off_ff;
   assign rec_pages         = needs_next ? nb_next : diff_next;
   assign rec_last_page     = end_of_region ? page_idx : PIDX_W'(PAGES - 1);

   always_comb begin
      base_in       = csr_wr_en ? csr_wr_data : base_ff;
      wis_in        = wis_ff;
      region_off_in = region_off_ff;
      sector_off_in = sector_off_ff;
      needs_in      = needs_ff;
      diff_in       = diff_ff;
      nb_in         = nb_ff;
      after_end_in  = after_end_ff;
      if (accept) begin
         after_end_in = end_of_region;
         if (decide) begin
            wis_in        = '0;
            needs_in      = 1'b0;
            diff_in       = '0;
            nb_in         = '0;
            region_off_in = end_of_region ? '0 : next_off;
            sector_off_in = end_of_region ? '0 : next_off;
         end else begin
            wis_in        = wis_ff + 1'b1;
            needs_in      = needs_next;
            diff_in       = diff_next;
            nb_in         = nb_next;
            region_off_in = next_off;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         wis_ff        <= '0;
         region_off_ff <= '0;
         sector_off_ff <= '0;
         needs_ff      <= 1'b0;
         diff_ff       <= '0;
         nb_ff         <= '0;
         after_end_ff  <= 1'b0;
      end else begin
         base_ff       <= base_in;
         wis_ff        <= wis_in;
         region_off_ff <= region_off_in;
         sector_off_ff <= sector_off_in;
         needs_ff      <= needs_in;
         diff_ff       <= diff_in;
         nb_ff         <= nb_in;
         after_end_ff  <= after_end_in;
      end
   end

endmodule

`default_nettype wire

// File: design/fepp_queue.sv
// Short first-in first-out queue of sector records between front and back.
`default_nettype none

module fepp_queue
   import fepp_pkg::*;
#(
   parameter int unsigned DATA_W = REC_BITS,
   parameter int unsigned DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wr_data,
   output logic              full,
   input  logic              pop,
   output logic              rd_valid,
   output logic [DATA_W-1:0] rd_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: design/fepp_back.sv
// Back end: walks sector records, merges runs and drives the command output register.
`default_nettype none

module fepp_back
   import fepp_pkg::*;
#(
   parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
   parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF,
   localparam int unsigned PAGES       = SECTOR_BYTES / PAGE_BYTES,
   localparam int unsigned PIDX_W      = (PAGES > 1) ? $clog2(PAGES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rec_valid,
   output logic                 rec_pop,
   input  sector_rec_type       rec,
   input  logic [PAGES-1:0]     rec_pages,
   input  logic [PIDX_W-1:0]    rec_last_page,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [1:0]           out_kind,
   output logic [ADDR_BITS-1:0] out_start,
   output logic [ADDR_BITS-1:0] out_bytes
);

   localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DONE_PRE,
      ST_ERASE,
      ST_PAGES,
      ST_END_ERASE,
      ST_END_PROG,
      ST_END_DONE
   } state_type;

   state_type            state_ff, state_in;
   sector_rec_type       cur_ff, cur_in;
   logic [PAGES-1:0]     pages_ff, pages_in;
   logic [PIDX_W-1:0]    last_page_ff, last_page_in;
   logic [PIDX_W-1:0]    page_ff, page_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 hold_ff, hold_in;
   logic                 erase_open_ff, erase_open_in;
   logic [ADDR_BITS-1:0] erase_start_ff, erase_start_in;
   logic [ADDR_BITS-1:0] erase_len_ff, erase_len_in;
   logic                 prog_open_ff, prog_open_in;
   logic [ADDR_BITS-1:0] prog_start_ff, prog_start_in;
   logic [ADDR_BITS-1:0] prog_len_ff, prog_len_in;
   logic                 out_valid_ff, out_valid_in;
   cmd_kind_type         out_kind_ff, out_kind_in;
   logic [ADDR_BITS-1:0] out_start_ff, out_start_in;
   logic [ADDR_BITS-1:0] out_bytes_ff, out_bytes_in;

   logic                 out_free, emit_go, advance;
   cmd_kind_type         emit_kind;
   logic [ADDR_BITS-1:0] emit_start, emit_bytes;
   logic [ADDR_BITS:0]   erase_sum, prog_sum;
   logic [ADDR_BITS-1:0] erase_grown, prog_grown, page_start;

   assign out_free    = !out_valid_ff || out_ready;
   assign erase_sum   = {1'b0, erase_len_ff} + (ADDR_BITS + 1)'(SECTOR_BYTES);
   assign prog_sum    = {1'b0, prog_len_ff} + (ADDR_BITS + 1)'(PAGE_BYTES);
   assign erase_grown = erase_sum[ADDR_BITS] ? '1 : erase_sum[ADDR_BITS-1:0];
   assign prog_grown  = prog_sum[ADDR_BITS] ? '1 : prog_sum[ADDR_BITS-1:0];
   assign page_start  = cur_ff.sector_start
                      + ADDR_BITS'(ADDR_BITS'(page_ff) * PAGE_BYTES);

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      pages_in       = pages_ff;
      last_page_in   = last_page_ff;
      page_in        = page_ff;
      count_in       = count_ff;
      hold_in        = hold_ff;
      erase_open_in  = erase_open_ff;
      erase_start_in = erase_start_ff;
      erase_len_in   = erase_len_ff;
      prog_open_in   = prog_open_ff;
      prog_start_in  = prog_start_ff;
      prog_len_in    = prog_len_ff;
      rec_pop        = 1'b0;
      emit_go        = 1'b0;
      emit_kind      = KIND_DONE;
      emit_start     = '0;
      emit_bytes     = '0;
      advance        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (rec_valid) begin
               rec_pop      = 1'b1;
               cur_in       = rec;
               pages_in     = rec_pages;
               last_page_in = rec_last_page;
               page_in      = '0;
               count_in     = '0;
               if (rec.first && hold_ff) begin
                  state_in = ST_DONE_PRE;
               end else if (rec.decide) begin
                  state_in = ST_ERASE;
               end
            end
         end
         ST_DONE_PRE: begin
            // Release a done marker held over from the previous region.
            if (out_free) begin
               emit_go  = 1'b1;
               hold_in  = 1'b0;
               count_in = count_ff + 1'b1;
               state_in = cur_ff.decide ? ST_ERASE : ST_IDLE;
            end
         end
         ST_ERASE: begin
            if (cur_ff.erase) begin
               if (erase_open_ff) begin
                  erase_len_in = erase_grown;
               end else begin
                  erase_open_in  = 1'b1;
                  erase_start_in = cur_ff.sector_start;
                  erase_len_in   = ADDR_BITS'(SECTOR_BYTES);
               end
               state_in = ST_PAGES;
            end else if (erase_open_ff) begin
               if (out_free) begin
                  emit_go       = 1'b1;
                  emit_kind     = KIND_ERASE;
                  emit_start    = erase_start_ff;
                  emit_bytes    = erase_len_ff;
                  count_in      = count_ff + 1'b1;
                  erase_open_in = 1'b0;
                  state_in      = ST_PAGES;
               end
            end else begin
               state_in = ST_PAGES;
            end
         end
         ST_PAGES: begin
            if (pages_ff[page_ff]) begin
               if (prog_open_ff) begin
                  prog_len_in = prog_grown;
               end else begin
                  prog_open_in  = 1'b1;
                  prog_start_in = page_start;
                  prog_len_in   = ADDR_BITS'(PAGE_BYTES);
               end
               advance = 1'b1;
            end else if (prog_open_ff) begin
               if (out_free) begin
                  emit_go      = 1'b1;
                  emit_kind    = KIND_PROGRAM;
                  emit_start   = prog_start_ff;
                  emit_bytes   = prog_len_ff;
                  count_in     = count_ff + 1'b1;
                  prog_open_in = 1'b0;
                  advance      = 1'b1;
               end
            end else begin
               advance = 1'b1;
            end
            if (advance) begin
               if (page_ff == last_page_ff) begin
                  state_in = cur_ff.last ? ST_END_ERASE : ST_IDLE;
               end else begin
                  page_in = page_ff + 1'b1;
               end
            end
         end
         ST_END_ERASE: begin
            if (!erase_open_ff) begin
               state_in = ST_END_PROG;
            end else if (out_free) begin
               emit_go       = 1'b1;
               emit_kind     = KIND_ERASE;
               emit_start    = erase_start_ff;
               emit_bytes    = erase_len_ff;
               count_in      = count_ff + 1'b1;
               erase_open_in = 1'b0;
               state_in      = ST_END_PROG;
            end
         end
         ST_END_PROG: begin
            if (!prog_open_ff) begin
               state_in = ST_END_DONE;
            end else if (out_free) begin
               emit_go      = 1'b1;
               emit_kind    = KIND_PROGRAM;
               emit_start   = prog_start_ff;
               emit_bytes   = prog_len_ff;
               count_in     = count_ff + 1'b1;
               prog_open_in = 1'b0;
               state_in     = ST_END_DONE;
            end
         end
         ST_END_DONE: begin
            // A full command budget defers the marker to the next transfer.
            if (count_ff == CNT_W'(MAX_RESULTS)) begin
               hold_in  = 1'b1;
               state_in = ST_IDLE;
            end else if (out_free) begin
               emit_go  = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = emit_go ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
      out_kind_in  = emit_go ? emit_kind : out_kind_ff;
      out_start_in = emit_go ? emit_start : out_start_ff;
      out_bytes_in = emit_go ? emit_bytes : out_bytes_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         hold_ff       <= 1'b0;
         erase_open_ff <= 1'b0;
         prog_open_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         page_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         hold_ff       <= hold_in;
         erase_open_ff <= erase_open_in;
         prog_open_ff  <= prog_open_in;
         out_valid_ff  <= out_valid_in;
         page_ff       <= page_in;
      end
      cur_ff         <= cur_in;
      pages_ff       <= pages_in;
      last_page_ff   <= last_page_in;
      erase_start_ff <= erase_start_in;
      erase_len_ff   <= erase_len_in;
      prog_start_ff  <= prog_start_in;
      prog_len_ff    <= prog_len_in;
      out_kind_ff    <= out_kind_in;
      out_start_ff   <= out_start_in;
      out_bytes_ff   <= out_bytes_in;
   end

   assign out_valid = out_valid_ff;
   assign out_kind  = out_kind_ff;
   assign out_start = out_start_ff;
   assign out_bytes = out_bytes_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RESULTS))
      else $error("command count past budget");

   a_page_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAGES) |-> (page_ff <= last_page_ff))
      else $error("page walk past last page");

   a_hold_source: assert property (@(posedge clock) disable iff (reset)
      $rose(hold_ff) |-> $past(state_ff == ST_END_DONE))
      else $error("done marker held outside region end");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (emit_go && (emit_kind == KIND_DONE)) |-> (!erase_open_ff && !prog_open_ff))
      else $error("done marker with a run still open");

endmodule

`default_nettype wire

// File: design/flash_erase_program_planner_top.sv
// Top level of the flash erase/program planner: front end, record queue, back end.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+------------------------------------------
//  req     | in        | req_tvalid/tready   | tdata: old_word, new_word; tlast: end_of_region
//  rsp     | out       | rsp_tvalid/tready   | tdata: start_address, run_bytes; tuser: kind
//  csr     | in        | csr_wr_en           | csr_wr_data: base_address
//
// Cycles: one word pair per cycle while the record queue has room. A sector
//   record is loaded by the back end, which releases a done marker held over from the last
//   region, makes the erase decision and decides each page (SECTOR_BYTES / PAGE_BYTES
//   for a full sector); at region end it flushes the erase run, the program run and the done
//   marker. Each command also waits for the output register to be free. The back end sets
//   the pace only for very short regions.
// Reset: synchronous; clears base_address, all sector flags and both runs. No
//   clearing pass is needed.
// Stalls: req_tready drops only when the queue is full; a stalled rsp holds the
//   back end while the front keeps taking words.
`default_nettype none

module flash_erase_program_planner_top
   import fepp_pkg::*;
#(
   parameter int unsigned WORD_BITS    = WORD_BITS_DEF,
   parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
   parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF,
   parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [ADDR_BITS-1:0]    csr_wr_data,    // base_address
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2*FIELD_BITS-1:0] req_tdata,      // [31:0] old_word, [63:32] new_word
   input  logic                    req_tlast,      // end_of_region
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [2*ADDR_BITS-1:0]  rsp_tdata,      // [31:0] start_address, [63:32] run_bytes
   output logic [1:0]              rsp_tuser       // command_kind
);

   localparam int unsigned PAGES  = SECTOR_BYTES / PAGE_BYTES;
   localparam int unsigned PIDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int unsigned Q_W    = REC_BITS + PAGES + PIDX_W;

   // Front-end side of the queue
   sector_rec_type        f_rec;
   logic [PAGES-1:0]      f_pages;
   logic [PIDX_W-1:0]     f_last_page;
   logic                  q_push, q_full;

   // Back-end side of the queue
   sector_rec_type        b_rec;
   logic [PAGES-1:0]      b_pages;
   logic [PIDX_W-1:0]     b_last_page;
   logic                  q_pop, q_valid;
   logic [Q_W-1:0]        q_rd_data;

   logic [ADDR_BITS-1:0]  cmd_start, cmd_bytes;

   fepp_front #(
      .WORD_BITS    (WORD_BITS),
      .SECTOR_BYTES (SECTOR_BYTES),
      .PAGE_BYTES   (PAGE_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .old_word      (req_tdata[FIELD_BITS-1:0]),
      .new_word      (req_tdata[2*FIELD_BITS-1:FIELD_BITS]),
      .end_of_region (req_tlast),
      .rec_push      (q_push),
      .rec_full      (q_full),
      .rec           (f_rec),
      .rec_pages     (f_pages),
      .rec_last_page (f_last_page)
   );

   // Pack the record with its page flags so one queue carries the whole sector.
   fepp_queue #(
      .DATA_W (Q_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_data  ({f_last_page, f_pages, f_rec}),
      .full     (q_full),
      .pop      (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_rd_data)
   );

   assign b_rec       = sector_rec_type'(q_rd_data[REC_BITS-1:0]);
   assign b_pages     = q_rd_data[REC_BITS +: PAGES];
   assign b_last_page = q_rd_data[REC_BITS + PAGES +: PIDX_W];

   fepp_back #(
      .SECTOR_BYTES (SECTOR_BYTES),
      .PAGE_BYTES   (PAGE_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .rec_valid     (q_valid),
      .rec_pop       (q_pop),
      .rec           (b_rec),
      .rec_pages     (b_pages),
      .rec_last_page (b_last_page),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_kind      (rsp_tuser),
      .out_start     (cmd_start),
      .out_bytes     (cmd_bytes)
   );

   // Drop start and length side by side into the result transfer.
   assign rsp_tdata = {cmd_bytes, cmd_start};

endmodule

`default_nettype wire
